[src/ler_pkg.sv]
// Package for the line-editing ring buffer: character codes, item modes,
// controller states and the controller-to-datapath command bundle. No dependencies.
package ler_pkg;

   localparam int STORE_DEPTH_DEFAULT = 4096;
   localparam int MAX_LINE_DEFAULT    = 80 * (24 - 1);

   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_RETURN    = 8'd13;

   typedef enum logic [1:0] {
      MODE_KEY     = 2'd0,
      MODE_REQUEST = 2'd1,
      MODE_PULL    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } ctrl_cmd_type;

endpackage

[src/ler_if.sv]
// Stream interfaces for the line-editing ring buffer: request and response channels.
// Valid/ready handshake; no package dependency.
interface ler_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  key_char;
   logic [11:0] read_len;

   modport source (output valid, output mode, output key_char, output read_len, input ready);
   modport sink   (input valid, input mode, input key_char, input read_len, output ready);
endinterface

interface ler_rsp_if;
   logic       valid;
   logic       ready;
   logic       line_ready;
   logic       rejected;
   logic       char_dropped;
   logic       data_valid;
   logic [7:0] data_char;
   logic       last;

   modport source (output valid, output line_ready, output rejected, output char_dropped,
                   output data_valid, output data_char, output last, input ready);
   modport sink   (input valid, input line_ready, input rejected, input char_dropped,
                   input data_valid, input data_char, input last, output ready);
endinterface

[src/line_edit_ring_buffer.sv]
// Line-editing ring buffer top level: controller plus datapath on stream interfaces.
// The request and its store read are captured on accept; the result beat is registered in the execute state.
// No new request is taken while one executes; the result beat is held until rsp is ready.
// A new request beat is taken in the same cycle the held result beat is taken.
// Reset (synchronous): clears pointers, counts, pending and delivery state; the store
// itself is not cleared and needs no clearing pass.
module line_edit_ring_buffer #(
   parameter int STORE_DEPTH = ler_pkg::STORE_DEPTH_DEFAULT,
   parameter int MAX_LINE    = ler_pkg::MAX_LINE_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ler_req_if.sink   req_chan,
   ler_rsp_if.source rsp_chan
);
   import ler_pkg::*;

   ctrl_cmd_type cmd;

   ler_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd)
   );

   ler_datapath #(
      .STORE_DEPTH (STORE_DEPTH),
      .MAX_LINE    (MAX_LINE)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_mode         (req_chan.mode),
      .req_key_char     (req_chan.key_char),
      .req_read_len     (req_chan.read_len),
      .rsp_line_ready   (rsp_chan.line_ready),
      .rsp_rejected     (rsp_chan.rejected),
      .rsp_char_dropped (rsp_chan.char_dropped),
      .rsp_data_valid   (rsp_chan.data_valid),
      .rsp_data_char    (rsp_chan.data_char),
      .rsp_last         (rsp_chan.last)
   );

endmodule

[src/ler_ctrl.sv]
// Controller for the line-editing ring buffer: accept, execute, hold result beat.
// Depends on ler_pkg.
module ler_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output ler_pkg::ctrl_cmd_type cmd
);
   import ler_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_ready) begin
               state_in = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE) || ((state_ff == ST_HOLD) && rsp_ready);
      rsp_valid   = (state_ff == ST_HOLD);
      cmd.capture = req_valid && req_ready;
      cmd.execute = (state_ff == ST_EXEC);
   end

endmodule

[src/ler_datapath.sv]
// Datapath for the line-editing ring buffer: character store, pointers, counts,
// request state and result register. Depends on ler_pkg.
module ler_datapath #(
   parameter int STORE_DEPTH = ler_pkg::STORE_DEPTH_DEFAULT,
   parameter int MAX_LINE    = ler_pkg::MAX_LINE_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ler_pkg::ctrl_cmd_type cmd,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_key_char,
   input  logic [11:0]           req_read_len,
   output logic                  rsp_line_ready,
   output logic                  rsp_rejected,
   output logic                  rsp_char_dropped,
   output logic                  rsp_data_valid,
   output logic [7:0]            rsp_data_char,
   output logic                  rsp_last
);
   import ler_pkg::*;

   localparam int PTR_W = $clog2(STORE_DEPTH);
   localparam int LEN_W = $clog2(MAX_LINE + 1);
   localparam int CMP_W = (PTR_W > 12) ? PTR_W : 12;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);

   logic [7:0] mem [STORE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] nl_count_ff, nl_count_in;
   logic [LEN_W-1:0] pend_ff, pend_in;
   logic             deliv_ff, deliv_in;
   logic [LEN_W-1:0] remain_ff, remain_in;

   logic [1:0]  mode_ff;
   logic [7:0]  key_ff;
   logic [11:0] len_ff;
   logic [7:0]  rdata_ff;

   logic [PTR_W-1:0] raddr;
   logic             we;
   logic             ready_in, rej_in, drop_in, valid_in, last_in;
   logic [7:0]       dch_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_LAST : p - 1'b1;
   endfunction

   assign raddr = (mode_type'(req_mode) == MODE_PULL) ? rd_ptr_ff : ptr_prev(wr_ptr_ff);

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_ptr_ff] <= key_ff;
      end
      if (cmd.capture) begin
         rdata_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         key_ff  <= req_key_char;
         len_ff  <= req_read_len;
      end
      if (cmd.execute) begin
         rsp_line_ready   <= ready_in;
         rsp_rejected     <= rej_in;
         rsp_char_dropped <= drop_in;
         rsp_data_valid   <= valid_in;
         rsp_data_char    <= dch_in;
         rsp_last         <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         nl_count_ff <= '0;
         pend_ff     <= '0;
         deliv_ff    <= 1'b0;
         remain_ff   <= '0;
      end else if (cmd.execute) begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         nl_count_ff <= nl_count_in;
         pend_ff     <= pend_in;
         deliv_ff    <= deliv_in;
         remain_ff   <= remain_in;
      end
   end

   always_comb begin
      logic [LEN_W-1:0] rem_dec;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      count_in    = count_ff;
      nl_count_in = nl_count_ff;
      pend_in     = pend_ff;
      deliv_in    = deliv_ff;
      remain_in   = remain_ff;
      we          = 1'b0;
      ready_in    = 1'b0;
      rej_in      = 1'b0;
      drop_in     = 1'b0;
      valid_in    = 1'b0;
      dch_in      = '0;
      last_in     = 1'b0;
      rem_dec     = (remain_ff != '0) ? remain_ff - 1'b1 : '0;
      unique case (mode_type'(mode_ff))
         MODE_KEY: begin
            if (key_ff == CH_BACKSPACE) begin
               if ((count_ff != '0) && (rdata_ff != CH_NEWLINE)) begin
                  wr_ptr_in = ptr_prev(wr_ptr_ff);
                  count_in  = count_ff - 1'b1;
               end
            end else if (key_ff != CH_RETURN) begin
               if (count_ff != PTR_LAST) begin
                  we        = cmd.execute;
                  wr_ptr_in = ptr_next(wr_ptr_ff);
                  count_in  = count_ff + 1'b1;
                  if (key_ff == CH_NEWLINE) begin
                     nl_count_in = nl_count_ff + 1'b1;
                  end
               end else begin
                  drop_in = 1'b1;
               end
            end
            if ((pend_ff != '0) &&
                ((nl_count_in != '0) || (CMP_W'(count_in) >= CMP_W'(pend_ff)))) begin
               ready_in  = 1'b1;
               deliv_in  = 1'b1;
               remain_in = pend_ff;
               pend_in   = '0;
            end
         end
         MODE_REQUEST: begin
            if ((len_ff > 12'(MAX_LINE)) || (pend_ff != '0) || deliv_ff) begin
               rej_in = 1'b1;
            end else if (len_ff == '0) begin
               ready_in = 1'b1;
            end else if ((nl_count_ff != '0) || (CMP_W'(count_ff) >= CMP_W'(len_ff))) begin
               ready_in  = 1'b1;
               deliv_in  = 1'b1;
               remain_in = len_ff[LEN_W-1:0];
            end else begin
               pend_in = len_ff[LEN_W-1:0];
            end
         end
         MODE_PULL: begin
            if (deliv_ff && (count_ff != '0)) begin
               dch_in    = rdata_ff;
               valid_in  = 1'b1;
               rd_ptr_in = ptr_next(rd_ptr_ff);
               count_in  = count_ff - 1'b1;
               if ((rdata_ff == CH_NEWLINE) && (nl_count_ff != '0)) begin
                  nl_count_in = nl_count_ff - 1'b1;
               end
               if ((rdata_ff == CH_NEWLINE) || (rem_dec == '0)) begin
                  last_in   = 1'b1;
                  deliv_in  = 1'b0;
                  remain_in = '0;
               end else begin
                  remain_in = rem_dec;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[src/ler_checker.sv]
// Port-level checks for the line-editing ring buffer, bound to the top level.
// Depends only on the top-level ports.
module ler_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       line_ready,
   input logic       rejected,
   input logic       char_dropped,
   input logic       data_valid,
   input logic [7:0] data_char,
   input logic       last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_char) && $stable(last)
         && $stable(data_valid) && $stable(line_ready) && $stable(rejected))
      else $error("response beat changed while stalled");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
      else $error("result beat not two cycles after accept");

   a_idle_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !data_valid |-> (data_char == 8'd0) && !last)
      else $error("data fields set without delivered character");

   a_reject_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rejected |-> !line_ready && !data_valid && !char_dropped)
      else $error("rejected beat carries other results");

endmodule

bind line_edit_ring_buffer ler_checker u_ler_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .line_ready   (rsp_chan.line_ready),
   .rejected     (rsp_chan.rejected),
   .char_dropped (rsp_chan.char_dropped),
   .data_valid   (rsp_chan.data_valid),
   .data_char    (rsp_chan.data_char),
   .last         (rsp_chan.last)
);

[bench/line_edit_ring_buffer_tb.sv]
// Testbench for line_edit_ring_buffer: drives typed keys, line requests and pulls
// and checks each response beat against a predictor of the line buffer.
// Depends on ler_pkg, ler_req_if/ler_rsp_if and the line_edit_ring_buffer top level.
`timescale 1ns / 1ps

module line_edit_ring_buffer_tb;
   import ler_pkg::*;

   localparam int STORE_DEPTH = ler_pkg::STORE_DEPTH_DEFAULT;
   localparam int MAX_LINE    = ler_pkg::MAX_LINE_DEFAULT;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic       line_ready;
      logic       rejected;
      logic       char_dropped;
      logic       data_valid;
      logic [7:0] data_char;
      logic       last;
   } line_result_type;

   logic clock = 1'b0;
   logic reset;

   ler_req_if req_bus();
   ler_rsp_if rsp_bus();

   line_edit_ring_buffer DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   logic [7:0]  shadow_store [0:STORE_DEPTH-1];
   logic [11:0] wr_ptr        = '0;
   logic [11:0] rd_ptr        = '0;
   logic [11:0] buf_count     = '0;
   logic [11:0] nl_count      = '0;
   logic [10:0] pend_len      = '0;
   logic        delivering    = 1'b0;
   logic [10:0] remaining_len = '0;

   line_result_type expected_results [$];
   int mismatch_count     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;

   function automatic line_result_type predict_line_edit(input logic [1:0] mode,
                                                         input logic [7:0] key,
                                                         input logic [11:0] len);
      line_result_type r;
      logic [7:0]      ch;
      r = '0;
      case (mode)
         MODE_KEY: begin
            if (key == CH_BACKSPACE) begin
               if (buf_count != 0 && shadow_store[wr_ptr - 12'd1] != CH_NEWLINE) begin
                  wr_ptr    = wr_ptr - 12'd1;
                  buf_count = buf_count - 12'd1;
               end
            end else if (key != CH_RETURN) begin
               if (buf_count < STORE_DEPTH - 1) begin
                  shadow_store[wr_ptr] = key;
                  wr_ptr    = wr_ptr + 12'd1;
                  buf_count = buf_count + 12'd1;
                  if (key == CH_NEWLINE) nl_count = nl_count + 12'd1;
               end else begin
                  r.char_dropped = 1'b1;
               end
            end
            if (pend_len != 0 && (nl_count != 0 || buf_count >= pend_len)) begin
               r.line_ready  = 1'b1;
               delivering    = 1'b1;
               remaining_len = pend_len;
               pend_len      = '0;
            end
         end
         MODE_REQUEST: begin
            if (len > MAX_LINE || pend_len != 0 || delivering) begin
               r.rejected = 1'b1;
            end else if (len == 0) begin
               r.line_ready = 1'b1;
            end else if (nl_count != 0 || buf_count >= len) begin
               r.line_ready  = 1'b1;
               delivering    = 1'b1;
               remaining_len = len[10:0];
            end else begin
               pend_len = len[10:0];
            end
         end
         MODE_PULL: begin
            if (delivering && buf_count != 0) begin
               ch        = shadow_store[rd_ptr];
               rd_ptr    = rd_ptr + 12'd1;
               buf_count = buf_count - 12'd1;
               if (ch == CH_NEWLINE && nl_count != 0) nl_count = nl_count - 12'd1;
               if (remaining_len != 0) remaining_len = remaining_len - 11'd1;
               r.data_valid = 1'b1;
               r.data_char  = ch;
               if (ch == CH_NEWLINE || remaining_len == 0) begin
                  r.last        = 1'b1;
                  delivering    = 1'b0;
                  remaining_len = '0;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] random_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 12) return CH_NEWLINE;
      if (pick < 27) return CH_BACKSPACE;
      if (pick < 32) return CH_RETURN;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_item(input logic [1:0] mode, input logic [7:0] key,
                            input logic [11:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= mode;
      req_bus.key_char <= key;
      req_bus.read_len <= len;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_results.push_back(predict_line_edit(mode, key, len));
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_line_editing();
      send_item(MODE_KEY, CH_BACKSPACE, 12'd0);
      send_item(MODE_KEY, CH_RETURN, 12'd0);
      send_item(MODE_PULL, 8'h00, 12'd0);
      send_item(MODE_UNUSED, 8'hFF, 12'hFFF);
      send_item(MODE_REQUEST, 8'h00, 12'd0);
      send_item(MODE_REQUEST, 8'h00, 12'(MAX_LINE + 1));
      send_item(MODE_REQUEST, 8'hFF, 12'hFFF);
      send_item(MODE_KEY, 8'hFF, 12'd0);
      send_item(MODE_KEY, 8'h00, 12'hFFF);
      send_item(MODE_KEY, CH_NEWLINE, 12'd0);
      send_item(MODE_KEY, CH_BACKSPACE, 12'd0);
      send_item(MODE_KEY, 8'h78, 12'd0);
      send_item(MODE_KEY, CH_BACKSPACE, 12'd0);
      send_item(MODE_REQUEST, 8'h00, 12'd3);
      send_item(MODE_REQUEST, 8'h00, 12'd2);
      repeat (3) send_item(MODE_PULL, 8'h00, 12'd0);
      send_item(MODE_REQUEST, 8'h00, 12'd2);
      send_item(MODE_REQUEST, 8'h00, 12'd1);
      send_item(MODE_KEY, 8'h61, 12'd0);
      send_item(MODE_KEY, 8'h62, 12'd0);
      repeat (2) send_item(MODE_KEY, CH_BACKSPACE, 12'd0);
      send_item(MODE_PULL, 8'h00, 12'd0);
      send_item(MODE_KEY, 8'h63, 12'd0);
      send_item(MODE_KEY, 8'h64, 12'd0);
      repeat (2) send_item(MODE_PULL, 8'h00, 12'd0);
   endtask

   task automatic test_backpressure();
      hold_off_left = 300;
      repeat (12) send_item(MODE_KEY, random_key(), 12'd0);
      send_item(MODE_KEY, CH_NEWLINE, 12'd0);
      send_item(MODE_REQUEST, 8'h00, 12'd16);
      repeat (20) send_item(MODE_PULL, 8'h00, 12'd0);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int item_goal);
      int          done_items;
      int          pick;
      logic [1:0]  mode;
      logic [7:0]  key;
      logic [11:0] len;
      done_items = 0;
      while (done_items < item_goal) begin
         pick = $urandom_range(99);
         key  = 8'($urandom_range(255));
         len  = 12'($urandom_range(4095));
         if (delivering && buf_count != 0 && pick < 70) begin
            mode = MODE_PULL;
         end else if ((pend_len != 0 || delivering) && pick < 85) begin
            mode = MODE_KEY;
            key  = random_key();
         end else begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               mode = MODE_KEY;
               key  = random_key();
            end else if (pick < 72) begin
               mode = MODE_REQUEST;
               pick = $urandom_range(99);
               if (pick < 60)      len = 12'($urandom_range(16, 1));
               else if (pick < 75) len = 12'($urandom_range(MAX_LINE, 17));
               else if (pick < 83) len = '0;
               else if (pick < 88) len = 12'(MAX_LINE);
               else                len = 12'($urandom_range(4095, MAX_LINE + 1));
            end else if (pick < 95) begin
               mode = MODE_PULL;
            end else begin
               mode = MODE_UNUSED;
            end
         end
         send_item(mode, key, len);
         done_items++;
      end
   endtask

   always @(posedge clock) begin : check_results
      line_result_type got;
      line_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = '{rsp_bus.line_ready, rsp_bus.rejected, rsp_bus.char_dropped,
                 rsp_bus.data_valid, rsp_bus.data_char, rsp_bus.last};
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected beat at %0t: ready=%b rej=%b drop=%b valid=%b char=%h last=%b",
                        $realtime, got.line_ready, got.rejected, got.char_dropped,
                        got.data_valid, got.data_char, got.last);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch at %0t: expected ready=%b rej=%b drop=%b valid=%b ",
                            "char=%h last=%b, got ready=%b rej=%b drop=%b valid=%b char=%h last=%b"},
                           $realtime, want.line_ready, want.rejected, want.char_dropped,
                           want.data_valid, want.data_char, want.last,
                           got.line_ready, got.rejected, got.char_dropped,
                           got.data_valid, got.data_char, got.last);
            end
         end
      end
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_KEY;
      req_bus.key_char = '0;
      req_bus.read_len = '0;
      rsp_bus.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_line_editing();
      wait_drained();
      test_backpressure();

      test_random_traffic(260);
      wait_drained();
      sender_idle_pct = 83;
      test_random_traffic(260);
      wait_drained();
      sender_idle_pct    = 0;
      receiver_stall_pct = 83;
      test_random_traffic(260);
      wait_drained();
      sender_idle_pct    = 16;
      receiver_stall_pct = 16;
      test_random_traffic(270);
      wait_drained();

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
